// ===== hdl/tsdl_pkg.sv =====
// tsdl_pkg: shared widths, request codes and controller/datapath interface types
// for the bounded top-k sorted distance list. no dependencies.

package tsdl_pkg;

  localparam int DEF_MAX_K = 16;

  localparam int DIST_W    = 32;
  localparam int ID_W      = 16;
  localparam int REQ_W     = 2;
  localparam int IDX_W     = 4;
  localparam int KCFG_W    = 5;
  localparam int CNT_OUT_W = 5;

  localparam logic [KCFG_W-1:0] K_RESET = 5'd16;

  // request codes; any other code changes nothing and reports like a read
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic load_item;
    logic compare;
    logic update;
    logic read_entry;
    logic read_bound;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/tsdl_ctrl.sv =====
// tsdl_ctrl: sequencer for the top-k list, one item at a time through
// compare, update and two reads. depends on tsdl_pkg.

module tsdl_ctrl
  import tsdl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CMP  = 6'b000010,
    ST_UPD  = 6'b000100,
    ST_RDE  = 6'b001000,
    ST_RDB  = 6'b010000,
    ST_LOAD = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_next  = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_next = ST_RDE;
      end
      ST_RDE: begin
        cmd.read_entry = 1'b1;
        state_next     = ST_RDB;
      end
      ST_RDB: begin
        cmd.read_bound = 1'b1;
        state_next     = ST_LOAD;
      end
      ST_LOAD: begin
        // wait here until the previous result has been transferred
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != ST_IDLE);

endmodule

// ===== hdl/tsdl_dpath.sv =====
// tsdl_dpath: list cells with broadcast compare, count, k register, shared
// read mux and output register. depends on tsdl_pkg.

module tsdl_dpath
  import tsdl_pkg::*;
#(
  parameter int MAX_K = DEF_MAX_K
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [DIST_W-1:0]    new_distance,
  input  logic [ID_W-1:0]      new_node_id,
  input  logic [IDX_W-1:0]     read_index,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [KCFG_W-1:0]    cfg_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [DIST_W-1:0]    entry_distance,
  output logic [ID_W-1:0]      entry_node_id,
  output logic [DIST_W-1:0]    bound_distance,
  output logic [CNT_OUT_W-1:0] list_count,
  output logic                 was_inserted,
  output logic                 was_duplicate
);

  localparam int CW = $clog2(MAX_K + 1);
  localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  // list cells
  logic [DIST_W-1:0] dist_q [MAX_K];
  logic [ID_W-1:0]   id_q   [MAX_K];
  logic [DIST_W-1:0] dist_next [MAX_K];
  logic [ID_W-1:0]   id_next   [MAX_K];
  logic [DIST_W-1:0] prev_dist [MAX_K];
  logic [ID_W-1:0]   prev_id   [MAX_K];
  logic [MAX_K-1:0]  prev_lt;

  logic [CW-1:0]     count, count_next;
  logic [KCFG_W-1:0] k_cfg;

  // latched item
  logic [REQ_W-1:0]  req_q;
  logic [DIST_W-1:0] ndist_q;
  logic [ID_W-1:0]   nid_q;
  logic [IDX_W-1:0]  ridx_q;

  logic [MAX_K-1:0]  lt_c, eq_c, lt_vec, eq_vec;
  logic [CW-1:0]     keff, kept;
  logic              full, is_dup, upd_en;

  logic [AW-1:0]     rd_addr;
  logic [DIST_W-1:0] rd_dist;
  logic [ID_W-1:0]   rd_id;
  logic              ridx_ok;

  // staged results
  logic [DIST_W-1:0] ent_d, bnd_d;
  logic [ID_W-1:0]   ent_id;
  logic              ins_r, dup_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_cfg <= K_RESET;
    end else if (cfg_valid) begin
      k_cfg <= cfg_data;
    end
  end

  // zero acts as one, anything above the cell count as the cell count
  always_comb begin
    if (k_cfg == '0) begin
      keff = CW'(1);
    end else if (int'(k_cfg) > MAX_K) begin
      keff = CW'(MAX_K);
    end else begin
      keff = CW'(k_cfg);
    end
  end

  assign full = (count >= keff);
  assign kept = full ? (keff - 1'b1) : count;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      req_q   <= req_type;
      ndist_q <= new_distance;
      nid_q   <= new_node_id;
      ridx_q  <= read_index;
    end
  end

  // broadcast compare against every cell
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      lt_c[i] = (CW'(i) < kept) && (dist_q[i] < ndist_q);
      eq_c[i] = (CW'(i) < count) && (dist_q[i] == ndist_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      lt_vec <= lt_c;
      eq_vec <= eq_c;
    end
  end

  for (genvar g = 0; g < MAX_K; g++) begin : g_prev
    if (g == 0) begin : g_first
      assign prev_dist[g] = '1;
      assign prev_id[g]   = '0;
      assign prev_lt[g]   = 1'b1;
    end else begin : g_rest
      assign prev_dist[g] = dist_q[g-1];
      assign prev_id[g]   = id_q[g-1];
      assign prev_lt[g]   = lt_vec[g-1];
    end
  end

  assign is_dup = |eq_vec;

  // lt_vec is a run of ones from cell 0: the first zero is the slot
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      if (req_q == REQ_CLEAR) begin
        dist_next[i] = '1;
        id_next[i]   = '0;
      end else if (lt_vec[i]) begin
        dist_next[i] = dist_q[i];
        id_next[i]   = id_q[i];
      end else if (prev_lt[i]) begin
        dist_next[i] = ndist_q;
        id_next[i]   = nid_q;
      end else if (CW'(i) <= kept) begin
        dist_next[i] = prev_dist[i];
        id_next[i]   = prev_id[i];
      end else begin
        dist_next[i] = '1;
        id_next[i]   = '0;
      end
    end
  end

  always_comb begin
    if (req_q == REQ_CLEAR) begin
      count_next = '0;
    end else if (full) begin
      count_next = keff;
    end else begin
      count_next = count + 1'b1;
    end
  end

  assign upd_en = cmd.update &&
                  ((req_q == REQ_CLEAR) || ((req_q == REQ_INSERT) && !is_dup));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < MAX_K; i++) begin
        dist_q[i] <= '1;
        id_q[i]   <= '0;
      end
    end else if (upd_en) begin
      count <= count_next;
      for (int i = 0; i < MAX_K; i++) begin
        dist_q[i] <= dist_next[i];
        id_q[i]   <= id_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      ins_r <= (req_q == REQ_INSERT) && !is_dup;
      dup_r <= (req_q == REQ_INSERT) && is_dup;
    end
  end

  // one read mux, shared by the entry read and the bound read
  assign rd_addr = cmd.read_bound ? AW'(keff - 1'b1) : AW'(ridx_q);
  assign rd_dist = dist_q[rd_addr];
  assign rd_id   = id_q[rd_addr];
  assign ridx_ok = (int'(ridx_q) < int'(count)) && (int'(ridx_q) < MAX_K);

  always_ff @(posedge clk) begin
    if (cmd.read_entry) begin
      ent_d  <= ridx_ok ? rd_dist : '1;
      ent_id <= ridx_ok ? rd_id : '0;
    end
    if (cmd.read_bound) begin
      bnd_d <= full ? rd_dist : '1;
    end
  end

  // output register
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      entry_distance <= ent_d;
      entry_node_id  <= ent_id;
      bound_distance <= bnd_d;
      list_count     <= CNT_OUT_W'(count);
      was_inserted   <= ins_r;
      was_duplicate  <= dup_r;
    end
  end

  a_lt_thermo: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> ((lt_vec & (lt_vec + 1'b1)) == '0))
    else $error("insert compare vector is not a run from cell 0");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && (req_q == REQ_CLEAR)) |=> (count == '0))
    else $error("clear did not empty the list");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && (req_q == REQ_INSERT) && !is_dup) |=> (count != '0 && ins_r))
    else $error("accepted insert left the list empty");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output register overwritten before transfer");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> !(was_inserted && was_duplicate))
    else $error("inserted and duplicate flagged together");

endmodule

// ===== hdl/topk_sorted_distance_list.sv =====
// topk_sorted_distance_list: top level of the bounded top-k sorted distance list.
// depends on tsdl_pkg, tsdl_ctrl and tsdl_dpath.
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+------------------
//  in      | req_type new_distance new_node_id         | in  | in_valid/in_stall
//          | read_index                                |     |
//  out     | entry_distance entry_node_id              | out | out_valid/out_stall
//          | bound_distance list_count was_inserted    |     |
//          | was_duplicate                             |     |
//  cfg     | cfg_data (k_in_use)                       | in  | cfg_valid/cfg_ready
//
// after an input transfer, in_stall is held while the sequencer walks compare,
// update, entry read and bound read through the single shared read mux,
// then loads the output register, which makes the result valid, once the
// output is free.
// reset (rst, synchronous) empties the list and sets k_in_use to 16.
// a stalled result holds in the output register while the next item is taken.

module topk_sorted_distance_list
  import tsdl_pkg::*;
#(
  parameter int MAX_K = DEF_MAX_K
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [DIST_W-1:0]    new_distance,
  input  logic [ID_W-1:0]      new_node_id,
  input  logic [IDX_W-1:0]     read_index,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [KCFG_W-1:0]    cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DIST_W-1:0]    entry_distance,
  output logic [ID_W-1:0]      entry_node_id,
  output logic [DIST_W-1:0]    bound_distance,
  output logic [CNT_OUT_W-1:0] list_count,
  output logic                 was_inserted,
  output logic                 was_duplicate
);

  cmd_t  cmd;
  stat_t stat;

  tsdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tsdl_dpath #(
    .MAX_K (MAX_K)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_type       (req_type),
    .new_distance   (new_distance),
    .new_node_id    (new_node_id),
    .read_index     (read_index),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .entry_distance (entry_distance),
    .entry_node_id  (entry_node_id),
    .bound_distance (bound_distance),
    .list_count     (list_count),
    .was_inserted   (was_inserted),
    .was_duplicate  (was_duplicate)
  );

endmodule
